/* hw/rtl/lbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types and constants of the bounded Levenshtein matcher.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int MAX_PATTERN_DEF  = 32;
  localparam int MAX_DISTANCE_DEF = 3;

  localparam int PAT_WORDS  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_BYTES  = PAT_WORDS * CFG_DATA_W / 8;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_CFG_W  = 6;
  localparam int DIST_CFG_W = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_LENGTH    = 3'd4,
    REG_DISTANCE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PAT_BYTES*8-1:0] pattern;
    logic [LEN_CFG_W-1:0]   length;
    logic [DIST_CFG_W-1:0]  distance;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic is_match;
    logic still_alive;
  } out_word_t;

endpackage

/* hw/rtl/lbm_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_cfg_regs
// Configuration register file: pattern words, pattern length, distance.
// ----------------------------------------------------------------------------
module lbm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output lbm_pkg::cfg_t                      cfg
);

  logic [lbm_pkg::CFG_DATA_W-1:0] pat_r [lbm_pkg::PAT_WORDS];
  logic [lbm_pkg::LEN_CFG_W-1:0]  length_r;
  logic [lbm_pkg::DIST_CFG_W-1:0] distance_r;
  logic                           wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < lbm_pkg::PAT_WORDS; w++) begin
        pat_r[w] <= '0;
      end
      length_r   <= '0;
      distance_r <= '0;
    end else if (wr) begin
      unique case (lbm_pkg::cfg_reg_t'(cfg_index))
        lbm_pkg::REG_PAT_0_7:   pat_r[0]   <= cfg_data;
        lbm_pkg::REG_PAT_8_15:  pat_r[1]   <= cfg_data;
        lbm_pkg::REG_PAT_16_23: pat_r[2]   <= cfg_data;
        lbm_pkg::REG_PAT_24_31: pat_r[3]   <= cfg_data;
        lbm_pkg::REG_LENGTH:    length_r   <= cfg_data[lbm_pkg::LEN_CFG_W-1:0];
        lbm_pkg::REG_DISTANCE:  distance_r <= cfg_data[lbm_pkg::DIST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int w = 0; w < lbm_pkg::PAT_WORDS; w++) begin
      cfg.pattern[w*lbm_pkg::CFG_DATA_W +: lbm_pkg::CFG_DATA_W] = pat_r[w];
    end
    cfg.length   = length_r;
    cfg.distance = distance_r;
  end

endmodule

/* hw/rtl/lbm_nfa.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_nfa
// Bit-parallel Levenshtein NFA: one row of active positions per error count,
// advanced by one word per cycle while advance is high, with the epsilon closure applied.
// ----------------------------------------------------------------------------
module lbm_nfa #(
  parameter int MAX_PATTERN  = lbm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_DISTANCE = lbm_pkg::MAX_DISTANCE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  lbm_pkg::in_word_t  word,
  input  lbm_pkg::cfg_t      cfg,
  output lbm_pkg::out_word_t result
);

  localparam int RW     = MAX_PATTERN + 1;
  localparam int ND     = MAX_DISTANCE + 1;
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int DIST_W = $clog2(MAX_DISTANCE + 1);
  localparam logic [lbm_pkg::LEN_CFG_W:0]  MaxLen  = (lbm_pkg::LEN_CFG_W+1)'(MAX_PATTERN);
  localparam logic [DIST_W:0]              MaxDist = (DIST_W+1)'(MAX_DISTANCE);

  logic [RW-1:0]     rows_r   [ND];
  logic [RW-1:0]     rows_nxt [ND];
  logic [LEN_W-1:0]  len;
  logic [DIST_W-1:0] dist_sat;
  logic [RW-1:0]     all_m;
  logic [RW-1:0]     below_m;
  logic [RW-1:0]     mv;

  // saturate the configured bounds
  always_comb begin
    if ({1'b0, cfg.length} > MaxLen) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(cfg.length);
    end
    if ((DIST_W+1)'(cfg.distance) > MaxDist) begin
      dist_sat = DIST_W'(MAX_DISTANCE);
    end else begin
      dist_sat = DIST_W'(cfg.distance);
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_pos
    assign all_m[j]   = (len >= LEN_W'(j));
    assign below_m[j] = (len >  LEN_W'(j));
    if (j < MAX_PATTERN && j < lbm_pkg::PAT_BYTES) begin : g_cmp
      assign mv[j] = (cfg.pattern[j*8 +: 8] == word.text_byte);
    end else if (j < MAX_PATTERN) begin : g_zero
      assign mv[j] = (word.text_byte == 8'd0);
    end else begin : g_top
      assign mv[j] = 1'b0;
    end
  end

  always_comb begin
    logic [RW-1:0] n;
    for (int e = 0; e < ND; e++) begin
      n = '0;
      if (word.operation == lbm_pkg::OP_START) begin
        if (e == 0) begin
          n[0] = 1'b1;
        end
      end else begin
        n = (rows_r[e] & mv & below_m) << 1;
        if (e > 0) begin
          n = n | rows_r[e-1] | ((rows_r[e-1] & below_m) << 1);
        end
      end
      if (e > 0) begin
        n = n | ((rows_nxt[e-1] & below_m) << 1);
      end
      if (DIST_W'(e) > dist_sat) begin
        rows_nxt[e] = '0;
      end else begin
        rows_nxt[e] = n & all_m;
      end
    end
  end

  always_comb begin
    result.is_match    = 1'b0;
    result.still_alive = 1'b0;
    for (int e = 0; e < ND; e++) begin
      result.is_match    = result.is_match | rows_nxt[e][len];
      result.still_alive = result.still_alive | (|rows_nxt[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ND; e++) begin
        rows_r[e] <= (e == 0) ? RW'(1) : '0;
      end
    end else if (advance) begin
      for (int e = 0; e < ND; e++) begin
        rows_r[e] <= rows_nxt[e];
      end
    end
  end

endmodule

/* hw/rtl/levenshtein_bounded_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// levenshtein_bounded_matcher
// Decides whether a streamed text lies within a set edit distance of a
// configured pattern.
//
// Input channel (in_valid / in_stall / in_word): a word with operation 0
// restarts the text, with operation 1 it consumes text_byte. Each word
// yields one result word on the output channel (out_valid / out_stall /
// out_word) carrying is_match and still_alive for the text so far.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; write it only while no word is in flight.
// A word accepted into the input register has its result registered in the
// result register once it advances. Throughput: one word per cycle while
// out_stall is low, set by the row update of the NFA between the input
// register and the result register.
// Reset clears the valid flags, configuration and NFA rows, leaving only the start state active.
// While out_stall is high the result holds; one more word is taken into the
// input register, after which in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module levenshtein_bounded_matcher #(
  parameter int MAX_PATTERN  = lbm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_DISTANCE = lbm_pkg::MAX_DISTANCE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lbm_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lbm_pkg::out_word_t              out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lbm_pkg::cfg_t      cfg;
  lbm_pkg::in_word_t  in_word_r;
  lbm_pkg::out_word_t out_word_r;
  lbm_pkg::out_word_t result;
  logic               in_v_r;
  logic               in_v_nxt;
  logic               out_v_r;
  logic               out_v_nxt;
  logic               take;
  logic               adv;

  lbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbm_nfa #(
    .MAX_PATTERN  (MAX_PATTERN),
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_nfa (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (adv),
    .word    (in_word_r),
    .cfg     (cfg),
    .result  (result)
  );

  assign in_stall  = in_v_r & out_v_r & out_stall;
  assign take      = in_valid & ~in_stall;
  assign adv       = in_v_r & (~out_v_r | ~out_stall);
  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

  always_comb begin
    in_v_nxt  = in_v_r;
    out_v_nxt = out_v_r;
    if (take) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_word_r <= in_word;
    end
    if (adv) begin
      out_word_r <= result;
    end
  end

endmodule
